>>> hdl/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared constants, codes and types of the Ising lattice energy engine.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int MAX_SIDE_DEF  = 64;
    localparam int MAX_SITES_DEF = 4096;

    localparam int SIDE_W      = 7;
    localparam int FIELD_W     = 16;
    localparam int ACT_W       = 3;
    localparam int COORD_W     = 6;
    localparam int VALUE_W     = 29;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    localparam int BOND_W = 17;
    localparam int MAG_W  = 16;
    localparam int PROD_W = 32;

    localparam logic [ACT_W-1:0] ACT_SET   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FLIP  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DELTA = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BOND  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TOTAL = 3'd4;
    localparam logic [ACT_W-1:0] ACT_MAG   = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_ACT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               spin_value;
    } cmd_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
    } res_t;

endpackage

>>> hdl/ile_spin_mem.sv
// ----------------------------------------------------------------------------
// ile_spin_mem
// Spin bit store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ile_spin_mem
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic              wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic              rdata_a,
    output logic              rdata_b
);

    logic mem [DEPTH];
    logic rdata_a_reg;
    logic rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> hdl/ile_engine.sv
// ----------------------------------------------------------------------------
// ile_engine
// Sequencer: clear pass, site reads/writes and whole-lattice scan.
// ----------------------------------------------------------------------------
module ile_engine
    import ile_pkg::*;
#(
    parameter int MAX_SITES = MAX_SITES_DEF,
    parameter int ADDR_W    = $clog2(MAX_SITES_DEF)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [SIDE_W-1:0]         side_len,
    input  logic signed [FIELD_W-1:0] field_h,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  cmd_t                      cmd,
    output logic                      res_valid,
    input  logic                      res_ready,
    output res_t                      res,
    output logic                      mem_we,
    output logic [ADDR_W-1:0]         mem_waddr,
    output logic                      mem_wdata,
    output logic [ADDR_W-1:0]         mem_raddr_a,
    output logic [ADDR_W-1:0]         mem_raddr_b,
    input  logic                      mem_rdata_a,
    input  logic                      mem_rdata_b
);

    localparam int LIN_W = (2 * SIDE_W > ADDR_W) ? 2 * SIDE_W : ADDR_W;
    localparam int ST_W  = 4;

    localparam logic [ST_W-1:0] ST_CLEAR = 4'd0;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd1;
    localparam logic [ST_W-1:0] ST_RD0   = 4'd2;
    localparam logic [ST_W-1:0] ST_RD1   = 4'd3;
    localparam logic [ST_W-1:0] ST_RD2   = 4'd4;
    localparam logic [ST_W-1:0] ST_RD3   = 4'd5;
    localparam logic [ST_W-1:0] ST_SCAN  = 4'd6;
    localparam logic [ST_W-1:0] ST_TAIL  = 4'd7;
    localparam logic [ST_W-1:0] ST_FIN1  = 4'd8;
    localparam logic [ST_W-1:0] ST_FIN2  = 4'd9;
    localparam logic [ST_W-1:0] ST_DONE  = 4'd10;

    function automatic logic [LIN_W-1:0] lin_of(input logic [SIDE_W-1:0] r,
                                                input logic [SIDE_W-1:0] c,
                                                input logic [SIDE_W-1:0] l);
        return LIN_W'(r) * LIN_W'(l) + LIN_W'(c);
    endfunction

    function automatic logic oob_of(input logic [LIN_W-1:0] lin);
        return 32'(lin) >= MAX_SITES;
    endfunction

    function automatic logic signed [2:0] pm1(input logic same);
        return same ? 3'sd1 : -3'sd1;
    endfunction

    logic [ST_W-1:0]   state_reg;
    logic [ST_W-1:0]   state_next;
    logic [ADDR_W-1:0] clr_reg;
    logic              vld_reg;

    logic [ACT_W-1:0]  action_reg;
    logic [SIDE_W-1:0] r_reg;
    logic [SIDE_W-1:0] c_reg;
    logic [SIDE_W-1:0] rup_reg;
    logic [SIDE_W-1:0] rdn_reg;
    logic [SIDE_W-1:0] cl_reg;
    logic [SIDE_W-1:0] cr_reg;
    logic              spin_reg;

    logic [SIDE_W-1:0] i_reg;
    logic [SIDE_W-1:0] j_reg;
    logic [SIDE_W-1:0] jd_reg;
    logic [SIDE_W-1:0] i_dn;
    logic              oob_a_reg;
    logic              oob_b_reg;
    logic              s_reg;
    logic [2:0]        cnt_reg;
    logic              prev_reg;
    logic              first_reg;

    logic signed [BOND_W-1:0] bonds_reg;
    logic signed [MAG_W-1:0]  mag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    res_t                     res_reg;

    logic [LIN_W-1:0] lin_a;
    logic [LIN_W-1:0] lin_b;
    logic [LIN_W-1:0] lin_w;
    logic             bit_a;
    logic             bit_b;

    logic [SIDE_W-1:0]         in_row;
    logic [SIDE_W-1:0]         in_col;
    logic                      in_range_err;
    logic [STATUS_W-1:0]       in_status;
    logic                      scan_last;
    logic [2:0]                cnt_tot;
    logic signed [4:0]         nsum;
    logic signed [VALUE_W-1:0] tv;
    logic signed [VALUE_W-1:0] site_val;
    logic signed [2:0]         bond_step;
    logic signed [PROD_W-1:0]  e_wide;

    assign bit_a = mem_rdata_a & ~oob_a_reg;
    assign bit_b = mem_rdata_b & ~oob_b_reg;

    assign in_row       = SIDE_W'(cmd.row);
    assign in_col       = SIDE_W'(cmd.col);
    assign in_range_err = (in_row >= side_len) || (in_col >= side_len);
    assign scan_last    = (i_reg == side_len - 1'b1) && (j_reg == side_len - 1'b1);
    assign i_dn         = (i_reg == side_len - 1'b1) ? '0 : i_reg + 1'b1;

    always_comb
    begin
        if (cmd.action > ACT_MAG)
        begin
            in_status = STAT_BAD_ACT;
        end
        else if (cmd.action <= ACT_BOND && in_range_err)
        begin
            in_status = STAT_RANGE;
        end
        else
        begin
            in_status = STAT_OK;
        end
    end

    // memory access per state
    always_comb
    begin
        lin_a     = '0;
        lin_b     = '0;
        lin_w     = '0;
        mem_we    = 1'b0;
        mem_wdata = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                lin_w  = LIN_W'(clr_reg);
            end
            ST_RD0:
            begin
                lin_a = lin_of(r_reg, c_reg, side_len);
                lin_b = lin_of(rup_reg, c_reg, side_len);
                if (action_reg == ACT_SET)
                begin
                    lin_w     = lin_a;
                    mem_we    = ~oob_of(lin_a);
                    mem_wdata = spin_reg;
                end
            end
            ST_RD1:
            begin
                lin_a = lin_of(rdn_reg, c_reg, side_len);
                lin_b = lin_of(r_reg, cl_reg, side_len);
                if (action_reg == ACT_FLIP)
                begin
                    lin_w     = lin_of(r_reg, c_reg, side_len);
                    mem_we    = ~oob_a_reg;
                    mem_wdata = ~bit_a;
                end
            end
            ST_RD2:
            begin
                lin_a = lin_of(r_reg, cr_reg, side_len);
            end
            ST_SCAN:
            begin
                lin_a = lin_of(i_reg, j_reg, side_len);
                lin_b = lin_of(i_dn, j_reg, side_len);
            end
            default:
            begin
                lin_a = '0;
            end
        endcase
    end

    assign mem_raddr_a = lin_a[ADDR_W-1:0];
    assign mem_raddr_b = lin_b[ADDR_W-1:0];
    assign mem_waddr   = lin_w[ADDR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == ADDR_W'(MAX_SITES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (in_status != STAT_OK)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (cmd.action <= ACT_BOND)
                    begin
                        state_next = ST_RD0;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_RD0:
            begin
                state_next = (action_reg == ACT_SET) ? ST_DONE : ST_RD1;
            end
            ST_RD1:
            begin
                state_next = (action_reg == ACT_FLIP) ? ST_DONE : ST_RD2;
            end
            ST_RD2:
            begin
                state_next = ST_RD3;
            end
            ST_RD3:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_FIN1;
            end
            ST_FIN1:
            begin
                state_next = (action_reg == ACT_MAG) ? ST_DONE : ST_FIN2;
            end
            ST_FIN2:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // site result: nsum = 2 * (up neighbors) - 4
    always_comb
    begin
        cnt_tot  = cnt_reg + {2'b00, bit_a};
        nsum     = $signed({1'b0, cnt_tot, 1'b0}) - 5'sd4;
        tv       = (VALUE_W'(nsum) <<< 8) + VALUE_W'(field_h);
        if (action_reg == ACT_DELTA)
        begin
            site_val = s_reg ? (tv <<< 1) : -(tv <<< 1);
        end
        else
        begin
            site_val = s_reg ? VALUE_W'(nsum) : -VALUE_W'(nsum);
        end
    end

    // scan: vertical bond from port b, horizontal bonds from the row stream
    always_comb
    begin
        bond_step = pm1(bit_a == bit_b);
        if (jd_reg != '0)
        begin
            bond_step = bond_step + pm1(bit_a == prev_reg);
        end
        if (jd_reg == side_len - 1'b1)
        begin
            bond_step = bond_step + pm1(bit_a == first_reg);
        end
    end

    assign e_wide = -(PROD_W'(bonds_reg) <<< 8) - prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= (state_reg == ST_SCAN);
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        oob_a_reg <= oob_of(lin_a);
        oob_b_reg <= oob_of(lin_b);
        jd_reg    <= j_reg;

        if (vld_reg)
        begin
            mag_reg   <= mag_reg + MAG_W'(pm1(bit_a));
            bonds_reg <= bonds_reg + BOND_W'(bond_step);
            prev_reg  <= bit_a;
            if (jd_reg == '0)
            begin
                first_reg <= bit_a;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    action_reg     <= cmd.action;
                    r_reg          <= in_row;
                    c_reg          <= in_col;
                    rup_reg        <= (in_row == '0) ? side_len - 1'b1 : in_row - 1'b1;
                    rdn_reg        <= (in_row == side_len - 1'b1) ? '0 : in_row + 1'b1;
                    cl_reg         <= (in_col == '0) ? side_len - 1'b1 : in_col - 1'b1;
                    cr_reg         <= (in_col == side_len - 1'b1) ? '0 : in_col + 1'b1;
                    spin_reg       <= cmd.spin_value;
                    i_reg          <= '0;
                    j_reg          <= '0;
                    bonds_reg      <= '0;
                    mag_reg        <= '0;
                    res_reg.value  <= '0;
                    res_reg.status <= in_status;
                end
            end
            ST_RD1:
            begin
                s_reg   <= bit_a;
                cnt_reg <= {2'b00, bit_b};
            end
            ST_RD2:
            begin
                cnt_reg <= cnt_reg + {2'b00, bit_a} + {2'b00, bit_b};
            end
            ST_RD3:
            begin
                res_reg.value <= site_val;
            end
            ST_SCAN:
            begin
                if (j_reg == side_len - 1'b1)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + 1'b1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            ST_FIN1:
            begin
                prod_reg      <= PROD_W'(field_h) * PROD_W'(mag_reg);
                res_reg.value <= VALUE_W'(mag_reg);
            end
            ST_FIN2:
            begin
                res_reg.value <= e_wide[VALUE_W-1:0];
            end
            default:
            begin
                s_reg <= s_reg;
            end
        endcase
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule

>>> hdl/ising_lattice_energy_engine.sv
// ----------------------------------------------------------------------------
// ising_lattice_energy_engine
// Square Ising lattice with periodic borders and energy/magnetization queries.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_index/cfg_data write side_length (index 0) or field_h
//   (index 1, signed Q8.8); write only while no transfer is in flight.
//   One s_tdata transfer is one action; each produces one m_tdata transfer.
//   After reset the spin store is swept to all spin-down, one site per
//   cycle, over all MAX_SITES sites; s_tready stays low during that pass.
//   The scan reads one site and its lower neighbor per cycle over the two
//   read ports of the spin store; site actions read the store up to five
//   times, in states RD0, RD1 and RD2. One action is in work at a time.
//   The result sits in an output register; the next action is accepted
//   while it waits. If m_tready stays low the engine holds its following
//   result and s_tready drops until the register drains.
// ----------------------------------------------------------------------------
module ising_lattice_energy_engine
    import ile_pkg::*;
#(
    parameter int MAX_SIDE  = MAX_SIDE_DEF,
    parameter int MAX_SITES = MAX_SITES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [FIELD_W-1:0]     cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // action, row, col, spin_value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // value, status, zero pad
);

    localparam int ADDR_W = $clog2(MAX_SITES);

    logic [SIDE_W-1:0]         side_length_reg;
    logic signed [FIELD_W-1:0] field_h_reg;
    logic [SIDE_W-1:0]         side_eff;

    cmd_t cmd;
    res_t res;
    logic res_valid;
    logic res_ready;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_wdata;
    logic [ADDR_W-1:0] mem_raddr_a;
    logic [ADDR_W-1:0] mem_raddr_b;
    logic              mem_rdata_a;
    logic              mem_rdata_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_length_reg <= SIDE_W'(MAX_SIDE_DEF);
            field_h_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SIDE:  side_length_reg <= cfg_data[SIDE_W-1:0];
                CFG_FIELD: field_h_reg     <= cfg_data;
                default:   field_h_reg     <= field_h_reg;
            endcase
        end
    end

    always_comb
    begin
        if (side_length_reg < SIDE_W'(2))
        begin
            side_eff = SIDE_W'(2);
        end
        else if (32'(side_length_reg) > MAX_SIDE)
        begin
            side_eff = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_eff = side_length_reg;
        end
    end

    assign cmd.action     = s_tdata[2:0];
    assign cmd.row        = s_tdata[8:3];
    assign cmd.col        = s_tdata[14:9];
    assign cmd.spin_value = s_tdata[15];

    ile_engine #(
        .MAX_SITES (MAX_SITES),
        .ADDR_W    (ADDR_W)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .side_len    (side_eff),
        .field_h     (field_h_reg),
        .cmd_valid   (s_tvalid),
        .cmd_ready   (s_tready),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    ile_spin_mem #(
        .DEPTH  (MAX_SITES),
        .ADDR_W (ADDR_W)
    ) u_spin_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    assign res_ready = ~m_tvalid_reg | m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= {1'b0, res.status, res.value};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sim/ising_checker.sv
// ----------------------------------------------------------------------------
// ising_checker
// Watches the config port and both stream channels of the Ising lattice
// engine, keeps its own copy of the spin lattice and registers, predicts the
// result of every accepted action and compares it field by field with the
// results in arrival order.
// ----------------------------------------------------------------------------
module ising_checker
    import ile_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [FIELD_W-1:0]     cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // action, row, col, spin_value
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // value, status, zero pad
    output int                     results_done,
    output int                     error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    bit                        spins [MAX_SITES_DEF];
    logic [SIDE_W-1:0]         side_reg;
    logic signed [FIELD_W-1:0] field_reg;
    res_t                      pending_results [$];

    initial
    begin
        results_done = 0;
        error_count  = 0;
    end

    function automatic int spin_at(int r, int c, int side);
        int k;
        k = (r % side) * side + (c % side);
        if (k >= MAX_SITES_DEF)
            return -1;
        return spins[k] ? 1 : -1;
    endfunction

    function automatic int neighbor_sum(int r, int c, int side);
        return spin_at(r + side - 1, c, side) + spin_at(r + 1, c, side)
             + spin_at(r, c + side - 1, side) + spin_at(r, c + 1, side);
    endfunction

    // Applies one action to the lattice copy and returns its result.
    function automatic res_t apply_action(cmd_t cmd);
        int     side;
        int     r;
        int     c;
        int     k;
        int     s;
        longint h;
        longint val;
        longint bonds;
        longint mag;
        res_t   res;
        side = (side_reg < 2) ? 2 : ((side_reg > MAX_SIDE_DEF) ? MAX_SIDE_DEF : side_reg);
        h = field_reg;
        r = cmd.row;
        c = cmd.col;
        val = 0;
        res.status = STAT_OK;
        if (cmd.action > ACT_MAG)
        begin
            res.status = STAT_BAD_ACT;
        end
        else if (cmd.action <= ACT_BOND)
        begin
            if (r >= side || c >= side)
            begin
                res.status = STAT_RANGE;
            end
            else
            begin
                k = r * side + c;
                s = spin_at(r, c, side);
                case (cmd.action)
                    ACT_SET:
                        if (k < MAX_SITES_DEF) spins[k] = cmd.spin_value;
                    ACT_FLIP:
                        if (k < MAX_SITES_DEF) spins[k] = ~spins[k];
                    ACT_DELTA:
                        val = 2 * s * (longint'(neighbor_sum(r, c, side)) * 256 + h);
                    default:
                        val = s * neighbor_sum(r, c, side);
                endcase
            end
        end
        else
        begin
            bonds = 0;
            mag = 0;
            for (int i = 0; i < side; i++)
            begin
                for (int j = 0; j < side; j++)
                begin
                    s = spin_at(i, j, side);
                    mag += s;
                    bonds += s * (spin_at(i + 1, j, side) + spin_at(i, j + 1, side));
                end
            end
            val = (cmd.action == ACT_TOTAL) ? (-256 * bonds - h * mag) : mag;
        end
        res.value = val[VALUE_W-1:0];
        return res;
    endfunction

    always @(posedge clk)
    begin
        cmd_t                      cmd;
        res_t                      expected;
        logic signed [VALUE_W-1:0] got_value;
        logic [STATUS_W-1:0]       got_status;
        if (!rst_n)
        begin
            foreach (spins[i])
                spins[i] = 1'b0;
            side_reg  = SIDE_W'(MAX_SIDE_DEF);
            field_reg = '0;
            pending_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_value  = m_tdata[VALUE_W-1:0];
                got_status = m_tdata[VALUE_W +: STATUS_W];
                results_done++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with no action pending: value %0d status %0d",
                             $time, got_value, got_status);
                    error_count++;
                end
                else
                begin
                    expected = pending_results.pop_front();
                    if (got_value !== expected.value)
                    begin
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, expected.value, got_value);
                        error_count++;
                    end
                    if (got_status !== expected.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, expected.status, got_status);
                        error_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_SIDE)
                    side_reg = cfg_data[SIDE_W-1:0];
                else
                    field_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                cmd.action     = s_tdata[ACT_W-1:0];
                cmd.row        = s_tdata[ACT_W +: COORD_W];
                cmd.col        = s_tdata[ACT_W + COORD_W +: COORD_W];
                cmd.spin_value = s_tdata[ACT_W + 2 * COORD_W];
                pending_results.push_back(apply_action(cmd));
            end
        end
    end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the Ising lattice energy engine: a directed pass over the
// lattice corners, wraparound, out-of-range coordinates, invalid actions and
// saturated side lengths, then random action mixes over a series of side
// length and field settings, with random gaps on both stream channels.
// Checking is done by ising_checker.
// ----------------------------------------------------------------------------
module testbench;
    import ile_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ACT_W-1:0] ACT_BAD_LO  = 3'd6;
    localparam logic [ACT_W-1:0] ACT_BAD_HI  = 3'd7;
    localparam int               CYCLE_LIMIT = 3000000;
    localparam int               PHASE_ITEMS = 160;
    localparam int               TAIL_CYCLES = 4200;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [FIELD_W-1:0]     cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int results_done;
    int error_count;
    int items_sent = 0;
    int cycle_count = 0;
    int lattice_side = MAX_SIDE_DEF;
    bit sender_steady = 1'b0;
    bit receiver_steady = 1'b0;

    ising_lattice_energy_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ising_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .results_done (results_done),
        .error_count  (error_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stall before each transfer.
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            stall = receiver_steady ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_action(input logic [ACT_W-1:0] action,
                               input logic [COORD_W-1:0] row,
                               input logic [COORD_W-1:0] col,
                               input logic spin);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {spin, col, row, action};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (results_done == items_sent);
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [SIDE_W-1:0] side, input logic [FIELD_W-1:0] field);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SIDE;
        cfg_data  <= FIELD_W'(side);
        @(negedge clk);
        cfg_index <= CFG_FIELD;
        cfg_data  <= field;
        @(negedge clk);
        cfg_we <= 1'b0;
        lattice_side = (side < 2) ? 2 : ((side > MAX_SIDE_DEF) ? MAX_SIDE_DEF : side);
    endtask

    task automatic run_phase(input logic [SIDE_W-1:0] side, input logic [FIELD_W-1:0] field);
        int                 pick;
        logic [ACT_W-1:0]   action;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        write_cfg(side, field);
        sender_steady   = ($urandom_range(0, 3) == 0);
        receiver_steady = ($urandom_range(0, 3) == 0);
        repeat (PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                action = ACT_SET;
            else if (pick < 50)
                action = ACT_FLIP;
            else if (pick < 66)
                action = ACT_DELTA;
            else if (pick < 82)
                action = ACT_BOND;
            else if (pick < 86)
                action = ACT_W'($urandom_range(ACT_BAD_LO, ACT_BAD_HI));
            else if (pick < 93)
                action = ACT_TOTAL;
            else
                action = ACT_MAG;
            // full scans are slow on big lattices
            if ((action == ACT_TOTAL || action == ACT_MAG) && lattice_side >= 32
                && $urandom_range(0, 9) != 0)
                action = ACT_DELTA;
            if ($urandom_range(0, 9) == 0)
            begin
                row = COORD_W'($urandom_range(0, 63));
                col = COORD_W'($urandom_range(0, 63));
            end
            else
            begin
                row = COORD_W'($urandom_range(0, lattice_side - 1));
                col = COORD_W'($urandom_range(0, lattice_side - 1));
            end
            send_action(action, row, col, 1'($urandom_range(0, 1)));
        end
        drain();
    endtask

    initial
    begin
        logic [SIDE_W-1:0]  phase_sides [12];
        logic [FIELD_W-1:0] edge_fields [5];
        phase_sides = '{7'd2, 7'd3, 7'd8, 7'd16, 7'd64, 7'd1,
                        7'd33, 7'd7, 7'd12, 7'd127, 7'd5, 7'd24};
        edge_fields = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0100, 16'hFF00};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset lattice, corners and wraparound
        send_action(ACT_TOTAL, 0, 0, 0);
        send_action(ACT_MAG, 0, 0, 0);
        send_action(ACT_SET, 0, 0, 1);
        send_action(ACT_SET, 63, 63, 1);
        send_action(ACT_SET, 63, 0, 1);
        send_action(ACT_FLIP, 0, 63, 0);
        send_action(ACT_DELTA, 0, 0, 0);
        send_action(ACT_BOND, 0, 0, 0);
        send_action(ACT_BOND, 63, 63, 1);
        send_action(ACT_DELTA, 63, 63, 0);
        send_action(ACT_SET, 63, 63, 0);
        send_action(ACT_FLIP, 0, 0, 1);
        send_action(ACT_BAD_LO, 63, 63, 1);
        send_action(ACT_BAD_HI, 0, 0, 0);
        send_action(ACT_TOTAL, 0, 0, 0);
        send_action(ACT_MAG, 0, 0, 0);
        drain();

        // small lattice, most negative field, out-of-range coordinates
        write_cfg(7'd5, 16'h8000);
        send_action(ACT_SET, 4, 4, 1);
        send_action(ACT_DELTA, 4, 4, 0);
        send_action(ACT_SET, 5, 0, 1);
        send_action(ACT_FLIP, 0, 5, 0);
        send_action(ACT_DELTA, 63, 63, 0);
        send_action(ACT_BOND, 5, 5, 0);
        send_action(ACT_TOTAL, 63, 63, 1);
        send_action(ACT_MAG, 0, 0, 0);
        drain();

        // side below minimum saturates to 2
        write_cfg(7'd0, 16'h7FFF);
        send_action(ACT_DELTA, 1, 1, 0);
        send_action(ACT_BOND, 0, 2, 0);
        send_action(ACT_TOTAL, 0, 0, 0);
        drain();

        // side above maximum saturates to MAX_SIDE
        write_cfg(7'd127, 16'hFFFF);
        send_action(ACT_TOTAL, 0, 0, 0);
        drain();

        for (int i = 0; i < 12; i++)
            run_phase(phase_sides[i], (i < 5) ? edge_fields[i] : FIELD_W'($urandom));

        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
